// ===== sv/adrc_pkg.sv =====
package adrc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DIV_STEPS = 32 + FRAC_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam logic [31:0]        Q_ONE   = 32'd1 << FRAC_BITS;
   localparam logic [30:0]        PERIOD_RESET = 31'd6554;
   localparam logic [30:0]        PLANT_RESET  = 31'd1 << FRAC_BITS;

   // Register index, byte address 4*index; the last index holds no register
   typedef enum logic [2:0] {
      REG_LOOP_GAIN,
      REG_GAIN_ONE,
      REG_GAIN_TWO,
      REG_PERIOD,
      REG_PLANT_GAIN,
      REG_DRIVE_MIN,
      REG_DRIVE_MAX,
      REG_SPARE
   } reg_index_type;

   // Multiply operations of the shared multiplier, in issue order
   typedef enum logic [2:0] {
      OP_L1E,
      OP_L2E,
      OP_KF0,
      OP_BT,
      OP_Q,
      OP_P,
      OP_X0,
      OP_X1
   } op_type;

   typedef struct packed {
      logic   load_err;
      logic   mul;
      logic   wb;
      op_type op;
      logic   div_init;
      logic   div_step;
      logic   div_fin;
      logic   push;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } stat_type;

   typedef struct packed {
      logic [30:0]        loop_gain;
      logic [16:0]        observer_gain_one;
      logic [30:0]        observer_gain_two;
      logic [30:0]        sample_period;
      logic [30:0]        plant_gain;
      logic signed [31:0] drive_min;
      logic signed [31:0] drive_max;
   } cfg_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'(S32_MAX)) begin
         r = S32_MAX;
      end else if (x < 64'(S32_MIN)) begin
         r = S32_MIN;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/adrc_ctrl.sv =====
module adrc_ctrl
   import adrc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_WB,
      ST_DIV_INIT,
      ST_DIV_RUN,
      ST_DIV_FIN,
      ST_PUSH
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cmd          = '0;
      cmd.op       = op_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_err = 1'b1;
               op_in        = OP_L1E;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_WB;
         end
         ST_WB: begin
            cmd.wb = 1'b1;
            if (op_ff == OP_KF0) begin
               state_in = ST_DIV_INIT;
            end else if (op_ff == OP_X1) begin
               state_in = ST_PUSH;
            end else begin
               op_in    = op_type'(3'(op_ff) + 3'd1);
               state_in = ST_MUL;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_DIV_FIN;
            end
         end
         ST_DIV_FIN: begin
            cmd.div_fin = 1'b1;
            op_in       = OP_BT;
            state_in    = ST_MUL;
         end
         ST_PUSH: begin
            // hold until the output register can take the result
            if (out_free) begin
               cmd.push     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_L1E;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/adrc_dpath.sv =====
module adrc_dpath
   import adrc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic signed [31:0] error_sample,
   output logic signed [31:0] drive,
   output logic               clamped
);

   localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic [DIV_STEPS-1:0] QUO_POS_MAX = DIV_STEPS'(S32_MAX);
   localparam logic [DIV_STEPS-1:0] QUO_NEG_MAX = DIV_STEPS'(1) << 31;

   logic signed [31:0] e_ff, f0_ff, f1_ff, n_ff, bt_ff, q_ff, s_ff, v_ff;
   logic signed [31:0] x0_ff, x0_in, x1_ff, x1_in;
   logic signed [63:0] prod_ff;
   logic               hit_ff;
   logic signed [31:0] drive_ff;
   logic               clamped_ff;

   logic [DIV_STEPS-1:0] num_ff, num_in;
   logic [30:0]          rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 neg_ff;

   logic [30:0]        b0_eff;
   logic signed [31:0] op_a, op_b;
   logic signed [63:0] rnd;
   logic signed [31:0] mres;
   logic [31:0]        n_mag;
   logic [31:0]        rem_shift;
   logic               rem_ge;
   logic signed [31:0] u_val, v_lo, v_val;
   logic               hit_lo, hit_val;

   // a zero plant gain divides by one LSB
   assign b0_eff = (cfg.plant_gain == '0) ? 31'd1 : cfg.plant_gain;

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cmd.op)
         OP_L1E: begin
            op_a = {15'd0, cfg.observer_gain_one};
            op_b = e_ff;
         end
         OP_L2E: begin
            op_a = {1'b0, cfg.observer_gain_two};
            op_b = e_ff;
         end
         OP_KF0: begin
            op_a = {1'b0, cfg.loop_gain};
            op_b = f0_ff;
         end
         OP_BT: begin
            op_a = {1'b0, b0_eff};
            op_b = {1'b0, cfg.sample_period};
         end
         OP_Q: begin
            op_a = bt_ff;
            op_b = v_ff;
         end
         OP_P: begin
            op_a = {1'b0, cfg.sample_period};
            op_b = f1_ff;
         end
         OP_X0: begin
            op_a = Q_ONE - {15'd0, cfg.observer_gain_one};
            op_b = s_ff;
         end
         OP_X1: begin
            op_a = {1'b0, cfg.observer_gain_two};
            op_b = s_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // round half up, floor shift, saturate
   assign rnd  = prod_ff + ROUND_HALF;
   assign mres = sat32(rnd >>> FRAC_BITS);

   // restoring divider, one quotient bit per step
   assign n_mag     = n_ff[31] ? 32'(-n_ff) : 32'(n_ff);
   assign rem_shift = {rem_ff, num_ff[DIV_STEPS-1]};
   assign rem_ge    = rem_shift >= {1'b0, b0_eff};
   assign rem_in    = rem_ge ? 31'(rem_shift - {1'b0, b0_eff}) : rem_shift[30:0];
   assign num_in    = {num_ff[DIV_STEPS-2:0], rem_ge};
   assign stat.div_last = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   always_comb begin
      if (neg_ff) begin
         u_val = (num_ff >= QUO_NEG_MAX) ? S32_MIN : -$signed(num_ff[31:0]);
      end else begin
         u_val = (num_ff > QUO_POS_MAX) ? S32_MAX : $signed(num_ff[31:0]);
      end
      // lower limit first, so the upper wins when the limits cross
      v_lo   = u_val;
      hit_lo = 1'b0;
      if (u_val < cfg.drive_min) begin
         v_lo   = cfg.drive_min;
         hit_lo = 1'b1;
      end
      v_val   = v_lo;
      hit_val = hit_lo;
      if (v_lo > cfg.drive_max) begin
         v_val   = cfg.drive_max;
         hit_val = 1'b1;
      end
   end

   assign x0_in = (cmd.wb && cmd.op == OP_X0) ? mres : x0_ff;
   assign x1_in = (cmd.wb && cmd.op == OP_X1) ? sat32(64'(f1_ff) - 64'(mres)) : x1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x0_ff  <= '0;
         x1_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         x0_ff <= x0_in;
         x1_ff <= x1_in;
         if (cmd.div_init) begin
            cnt_ff <= '0;
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff + DIV_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_err) begin
         e_ff <= error_sample;
      end
      if (cmd.mul) begin
         prod_ff <= op_a * op_b;
      end
      if (cmd.wb) begin
         case (cmd.op)
            OP_L1E:  f0_ff <= sat32(64'(x0_ff) + 64'(mres));
            OP_L2E:  f1_ff <= sat32(64'(x1_ff) + 64'(mres));
            OP_KF0:  n_ff  <= sat32(64'(mres) + 64'(f1_ff));
            OP_BT:   bt_ff <= mres;
            OP_Q:    q_ff  <= mres;
            OP_P:    s_ff  <= sat32(64'(f0_ff) + 64'(mres) - 64'(q_ff));
            default: begin
            end
         endcase
      end
      if (cmd.div_init) begin
         num_ff <= {n_mag, FRAC_BITS'(0)};
         rem_ff <= '0;
         neg_ff <= n_ff[31];
      end else if (cmd.div_step) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
      if (cmd.div_fin) begin
         v_ff   <= v_val;
         hit_ff <= hit_val;
      end
      if (cmd.push) begin
         drive_ff   <= v_ff;
         clamped_ff <= hit_ff;
      end
   end

   assign drive   = drive_ff;
   assign clamped = clamped_ff;

endmodule

// ===== sv/adrc_first_order_step.sv =====
// First-order ADRC step for one axis, signed Q16.16.
// Input channel req_*: one control error sample per item. Result channel rsp_*:
// the clamped drive and a flag that is set when a drive limit acted.
// An item is taken when valid is high and stall is low; this block stalls the
// input while it works on an item and accepts one item at a time.
// Per item: three multiplies on the shared 32x32 multiplier (multiply state,
// then write-back state), a restoring divide by the plant gain (init, step loop
// and finish states, one quotient bit a cycle), five more multiplies and a push
// state that loads the output register. The next item is accepted only after
// that push, once the block is back in idle.
// A finished result waits in the output register while rsp_stall is high;
// the next item is accepted meanwhile, and its own result waits in the
// datapath until the output register is free.
// Reset stalls the input, clears the observer estimates to zero and loads the
// register defaults (T = 6554, b0 = 1.0, drive limits at the full 32-bit range).
// Registers are written over the APB port at byte address 4*index.
module adrc_first_order_step
   import adrc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_error_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_drive,
   output logic               rsp_clamped,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   cfg_type  cfg_ff;
   cmd_type  cmd;
   stat_type stat;
   logic     wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.loop_gain         <= '0;
         cfg_ff.observer_gain_one <= '0;
         cfg_ff.observer_gain_two <= '0;
         cfg_ff.sample_period     <= PERIOD_RESET;
         cfg_ff.plant_gain        <= PLANT_RESET;
         cfg_ff.drive_min         <= S32_MIN;
         cfg_ff.drive_max         <= S32_MAX;
      end else if (wr_en) begin
         case (reg_idx)
            REG_LOOP_GAIN:  cfg_ff.loop_gain         <= pwdata[30:0];
            REG_GAIN_ONE:   cfg_ff.observer_gain_one <= pwdata[16:0];
            REG_GAIN_TWO:   cfg_ff.observer_gain_two <= pwdata[30:0];
            REG_PERIOD:     cfg_ff.sample_period     <= pwdata[30:0];
            REG_PLANT_GAIN: cfg_ff.plant_gain        <= pwdata[30:0];
            REG_DRIVE_MIN:  cfg_ff.drive_min         <= pwdata;
            REG_DRIVE_MAX:  cfg_ff.drive_max         <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LOOP_GAIN:  prdata = {1'b0, cfg_ff.loop_gain};
         REG_GAIN_ONE:   prdata = {15'd0, cfg_ff.observer_gain_one};
         REG_GAIN_TWO:   prdata = {1'b0, cfg_ff.observer_gain_two};
         REG_PERIOD:     prdata = {1'b0, cfg_ff.sample_period};
         REG_PLANT_GAIN: prdata = {1'b0, cfg_ff.plant_gain};
         REG_DRIVE_MIN:  prdata = cfg_ff.drive_min;
         REG_DRIVE_MAX:  prdata = cfg_ff.drive_max;
         default:        prdata = '0;
      endcase
   end

   adrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   adrc_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .cmd          (cmd),
      .stat         (stat),
      .error_sample (req_error_sample),
      .drive        (rsp_drive),
      .clamped      (rsp_clamped)
   );

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_err, cmd.mul, cmd.wb, cmd.div_init, cmd.div_step,
                cmd.div_fin, cmd.push}))
      else $error("datapath commands overlap");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !(rsp_valid && rsp_stall))
      else $error("output register loaded while a result is held");

   a_div_no_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> req_stall)
      else $error("input open during divide");

   a_div_fin_order: assert property (@(posedge clock) disable iff (reset)
      cmd.div_fin |-> $past(cmd.div_step) && $past(stat.div_last))
      else $error("divide finished before its last step");

endmodule

// ===== test/adrc_first_order_step_tb.sv =====
`timescale 1ns / 100ps

module adrc_first_order_step_tb;
   import adrc_pkg::*;

   localparam int RANDOM_ITEMS = 1250;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_WAIT = 100;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int N_PLAN = 44;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum {STALL_NONE, STALL_SCATTER, STALL_HOLD} stall_mode_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic               clamped;
   } drive_type;

   typedef struct packed {
      row_kind_type  kind;
      reg_index_type reg_idx;
      logic [31:0]   data;
      logic          typed;
      drive_type     want;
   } step_row_type;

   typedef struct {
      logic [30:0]        loop_gain;
      logic [16:0]        gain_one;
      logic [30:0]        gain_two;
      logic [30:0]        period;
      logic [30:0]        plant;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
   } tuning_type;

   localparam drive_type ZERO_OUT = '{32'sh0, 1'b0};
   localparam drive_type UP_ONE = '{32'sh0001_0000, 1'b1};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_error_sample = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_drive;
   logic               rsp_clamped;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [4:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   tuning_type     tune;
   longint         est_x0;
   longint         est_x1;
   drive_type      drive_q[$];
   int             fail_count = 0;
   int             cycle_count = 0;
   int             burst_left = 0;
   int             stall_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   step_row_type   plan[N_PLAN];

   adrc_first_order_step i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_error_sample(req_error_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_drive       (rsp_drive),
      .rsp_clamped     (rsp_clamped),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clip32(input longint x);
      if (x > 64'sd2147483647) begin
         return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return x;
   endfunction

   // Rounded fixed-point product; arithmetic shift gives the floor
   function automatic longint qmul(input longint a, input longint b);
      longint p;
      p = a * b + (longint'(1) << (FRAC_BITS - 1));
      return clip32(p >>> FRAC_BITS);
   endfunction

   // One controller step: correct the observer, form the drive, advance the observer
   function automatic drive_type adrc_step(input logic signed [31:0] err);
      longint e, k, l1, l2, t, b0, f0, f1, n, u, v, bt, q, p, s;
      drive_type r;
      e = longint'(err);
      k = longint'(tune.loop_gain);
      l1 = longint'(tune.gain_one);
      l2 = longint'(tune.gain_two);
      t = longint'(tune.period);
      b0 = (tune.plant == '0) ? 64'sd1 : longint'(tune.plant);
      f0 = clip32(est_x0 + qmul(l1, e));
      f1 = clip32(est_x1 + qmul(l2, e));
      n = clip32(qmul(k, f0) + f1);
      u = clip32((n * (longint'(1) << FRAC_BITS)) / b0);
      v = u;
      r.clamped = 1'b0;
      // lower limit first, so the upper one wins when the two cross
      if (v < longint'(tune.lo)) begin
         v = longint'(tune.lo);
         r.clamped = 1'b1;
      end
      if (v > longint'(tune.hi)) begin
         v = longint'(tune.hi);
         r.clamped = 1'b1;
      end
      bt = qmul(b0, t);
      q = qmul(bt, v);
      p = qmul(t, f1);
      s = clip32(f0 + p - q);
      est_x0 = qmul((longint'(1) << FRAC_BITS) - l1, s);
      est_x1 = clip32(f1 - qmul(l2, s));
      r.drive = 32'(v);
      return r;
   endfunction

   function automatic logic [31:0] pick_value(input logic [31:0] typical_hi,
                                              input logic [31:0] mask);
      logic [31:0] v;
      case ($urandom_range(0, 7))
         0: v = '0;
         1: v = mask;
         2: v = $urandom & mask;
         default: v = $urandom_range(0, typical_hi);
      endcase
      return v;
   endfunction

   // Write a register, read it back, and track the new setting
   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] stored;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      stored = {1'b0, value[30:0]};
      case (idx)
         REG_LOOP_GAIN: tune.loop_gain = value[30:0];
         REG_GAIN_ONE: begin
            tune.gain_one = value[16:0];
            stored = {15'b0, value[16:0]};
         end
         REG_GAIN_TWO: tune.gain_two = value[30:0];
         REG_PERIOD: tune.period = value[30:0];
         REG_PLANT_GAIN: tune.plant = value[30:0];
         REG_DRIVE_MIN: begin
            tune.lo = value;
            stored = value;
         end
         REG_DRIVE_MAX: begin
            tune.hi = value;
            stored = value;
         end
         default: stored = readback;
      endcase
      if (readback !== stored) begin
         $display("%0t: register %s readback expected %h actual %h",
                  $time, idx.name(), stored, readback);
         fail_count++;
      end
   endtask

   // Drop valid and wait for every pending item to come back
   task automatic settle();
      req_valid <= 1'b0;
      while (drive_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic offer_error(input logic signed [31:0] e, input logic typed,
                              input drive_type want);
      int gap;
      drive_type predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         case ($urandom_range(0, 3))
            1: gap = $urandom_range(1, 8);
            2: gap = $urandom_range(9, 80);
            default: gap = 0;
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_error_sample <= e;
      do @(posedge clock); while (req_stall);
      predicted = adrc_step(e);
      drive_q.push_back(typed ? want : predicted);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 2));
            stall_left = (stall_mode == STALL_HOLD) ? $urandom_range(1, 40)
                                                    : $urandom_range(10, 200);
         end
         stall_left--;
         case (stall_mode)
            STALL_SCATTER: rsp_stall <= ($urandom_range(0, 2) == 0);
            STALL_HOLD: rsp_stall <= 1'b1;
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      drive_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_q.size() == 0) begin
            $display("%0t: result with no item pending, drive %h clamped %b",
                     $time, rsp_drive, rsp_clamped);
            fail_count++;
         end else begin
            want = drive_q.pop_front();
            if (rsp_drive !== want.drive) begin
               $display("%0t: drive expected %h actual %h", $time, want.drive, rsp_drive);
               fail_count++;
            end
            if (rsp_clamped !== want.clamped) begin
               $display("%0t: clamped expected %b actual %b",
                        $time, want.clamped, rsp_clamped);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("adrc_first_order_step_tb failed");
         $finish;
      end
   end

   initial begin
      int                 random_sent;
      int                 phase_items;
      logic signed [31:0] e;
      logic [31:0]        lim;
      logic [31:0]        lo;
      logic [31:0]        hi;

      tune.loop_gain = '0;
      tune.gain_one = '0;
      tune.gain_two = '0;
      tune.period = PERIOD_RESET;
      tune.plant = PLANT_RESET;
      tune.lo = S32_MIN;
      tune.hi = S32_MAX;
      est_x0 = 0;
      est_x1 = 0;
      random_sent = 0;

      plan = '{
         // defaults after reset: all gains zero, drive stays zero
         '{ROW_ITEM, REG_SPARE, 32'h7fff_ffff, 1'b1, ZERO_OUT},
         '{ROW_ITEM, REG_SPARE, 32'h8000_0000, 1'b1, ZERO_OUT},
         '{ROW_ITEM, REG_SPARE, 32'h0000_0000, 1'b1, ZERO_OUT},
         '{ROW_ITEM, REG_SPARE, 32'h0000_0001, 1'b1, ZERO_OUT},
         '{ROW_ITEM, REG_SPARE, 32'hffff_ffff, 1'b1, ZERO_OUT},
         // unit loop gain and l1, full correction, limits of +-1.0
         '{ROW_CSR, REG_LOOP_GAIN, 32'h0001_0000, 1'b0, ZERO_OUT},
         '{ROW_CSR, REG_GAIN_ONE, 32'h0001_0000, 1'b0, ZERO_OUT},
         '{ROW_CSR, REG_DRIVE_MIN, 32'hffff_0000, 1'b0, ZERO_OUT},
         '{ROW_CSR, REG_DRIVE_MAX, 32'h0001_0000, 1'b0, ZERO_OUT},
         '{ROW_ITEM, REG_SPARE, 32'h7fff_ffff, 1'b1, UP_ONE},
         '{ROW_ITEM, REG_SPARE, 32'h8000_0000, 1'b1, '{32'shffff_0000, 1'b1}},
         '{ROW_ITEM, REG_SPARE, 32'h0000_0000, 1'b1, ZERO_OUT},
         '{ROW_ITEM, REG_SPARE, 32'h0000_8000, 1'b1, '{32'sh0000_8000, 1'b0}},
         // crossed limits: upper limit wins
         '{ROW_CSR, REG_DRIVE_MIN, 32'h0002_0000, 1'b0, ZERO_OUT},
         '{ROW_ITEM, REG_SPARE, 32'h0000_0000, 1'b1, UP_ONE},
         '{ROW_ITEM, REG_SPARE, 32'h8000_0000, 1'b1, UP_ONE},
         // saturating gains, l1 above one, zero plant gain
         '{ROW_CSR, REG_DRIVE_MIN, 32'h8000_0000, 1'b0, ZERO_OUT},
         '{ROW_CSR, REG_DRIVE_MAX, 32'h7fff_ffff, 1'b0, ZERO_OUT},
         '{ROW_CSR, REG_GAIN_ONE, 32'h0001_ffff, 1'b0, ZERO_OUT},
         '{ROW_CSR, REG_GAIN_TWO, 32'h7fff_ffff, 1'b0, ZERO_OUT},
         '{ROW_CSR, REG_LOOP_GAIN, 32'h7fff_ffff, 1'b0, ZERO_OUT},
         '{ROW_CSR, REG_PERIOD, 32'h7fff_ffff, 1'b0, ZERO_OUT},
         '{ROW_CSR, REG_PLANT_GAIN, 32'h0000_0000, 1'b0, ZERO_OUT},
         '{ROW_ITEM, REG_SPARE, 32'h7fff_ffff, 1'b0, ZERO_OUT},
         '{ROW_ITEM, REG_SPARE, 32'h8000_0000, 1'b0, ZERO_OUT},
         '{ROW_ITEM, REG_SPARE, 32'h1234_5678, 1'b0, ZERO_OUT},
         '{ROW_ITEM, REG_SPARE, 32'hffff_fffb, 1'b0, ZERO_OUT},
         '{ROW_CSR, REG_PLANT_GAIN, 32'h7fff_ffff, 1'b0, ZERO_OUT},
         '{ROW_CSR, REG_PERIOD, 32'h0000_0001, 1'b0, ZERO_OUT},
         '{ROW_CSR, REG_LOOP_GAIN, 32'h0000_0000, 1'b0, ZERO_OUT},
         '{ROW_ITEM, REG_SPARE, 32'h7fff_ffff, 1'b0, ZERO_OUT},
         '{ROW_ITEM, REG_SPARE, 32'hedcb_a987, 1'b0, ZERO_OUT},
         '{ROW_ITEM, REG_SPARE, 32'h0000_0000, 1'b0, ZERO_OUT},
         // moderate tuning; a write to the unused address must change nothing
         '{ROW_CSR, REG_LOOP_GAIN, 32'h0002_0000, 1'b0, ZERO_OUT},
         '{ROW_CSR, REG_GAIN_ONE, 32'h0000_8000, 1'b0, ZERO_OUT},
         '{ROW_CSR, REG_GAIN_TWO, 32'h0002_0000, 1'b0, ZERO_OUT},
         '{ROW_CSR, REG_PERIOD, 32'h0000_199a, 1'b0, ZERO_OUT},
         '{ROW_CSR, REG_PLANT_GAIN, 32'h0001_0000, 1'b0, ZERO_OUT},
         '{ROW_CSR, REG_DRIVE_MIN, 32'hff9c_0000, 1'b0, ZERO_OUT},
         '{ROW_CSR, REG_DRIVE_MAX, 32'h0064_0000, 1'b0, ZERO_OUT},
         '{ROW_CSR, REG_SPARE, 32'hffff_ffff, 1'b0, ZERO_OUT},
         '{ROW_ITEM, REG_SPARE, 32'h0003_0000, 1'b0, ZERO_OUT},
         '{ROW_ITEM, REG_SPARE, 32'hfffd_0000, 1'b0, ZERO_OUT},
         '{ROW_ITEM, REG_SPARE, 32'h0000_1000, 1'b0, ZERO_OUT}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            csr_write(plan[i].reg_idx, plan[i].data);
         end else begin
            offer_error(plan[i].data, plan[i].typed, plan[i].want);
         end
      end

      while (random_sent < RANDOM_ITEMS) begin
         settle();
         csr_write(REG_LOOP_GAIN, pick_value(32'h0004_0000, 32'h7fff_ffff));
         csr_write(REG_GAIN_ONE, pick_value(32'h0001_0000, 32'h0001_ffff));
         csr_write(REG_GAIN_TWO, pick_value(32'h0008_0000, 32'h7fff_ffff));
         csr_write(REG_PERIOD, pick_value(32'h0001_0000, 32'h7fff_ffff));
         csr_write(REG_PLANT_GAIN, pick_value(32'h0004_0000, 32'h7fff_ffff));
         case ($urandom_range(0, 3))
            0: begin
               lo = 32'h8000_0000;
               hi = 32'h7fff_ffff;
            end
            1, 2: begin
               lim = $urandom_range(1, 32'h0010_0000);
               lo = -lim;
               hi = lim;
            end
            default: begin
               lo = $urandom;
               hi = $urandom;
            end
         endcase
         csr_write(REG_DRIVE_MIN, lo);
         csr_write(REG_DRIVE_MAX, hi);
         if ($urandom_range(0, 3) == 0) begin
            csr_write(REG_SPARE, $urandom);
         end

         phase_items = $urandom_range(60, 160);
         if (phase_items > RANDOM_ITEMS - random_sent) begin
            phase_items = RANDOM_ITEMS - random_sent;
         end
         repeat (phase_items) begin
            case ($urandom_range(0, 9))
               0: begin
                  case ($urandom_range(0, 3))
                     0: e = 32'sh7fff_ffff;
                     1: e = 32'sh8000_0000;
                     2: e = 32'sh0;
                     default: e = -32'sd1;
                  endcase
               end
               1, 2, 3: e = $urandom;
               default: e = 32'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            endcase
            offer_error(e, 1'b0, ZERO_OUT);
            random_sent++;
         end
      end

      req_valid <= 1'b0;
      while (drive_q.size() != 0) @(posedge clock);
      repeat (END_WAIT) @(posedge clock);
      if (fail_count == 0 && drive_q.size() == 0) begin
         $display("adrc_first_order_step_tb passed");
      end else begin
         $display("adrc_first_order_step_tb failed");
      end
      $finish;
   end

endmodule
